// ----- sv/subarray_at_least_half_counter_macros.svh -----
// assertion macros shared by the checker of the subarray counter
`ifndef SUBARRAY_AT_LEAST_HALF_COUNTER_MACROS_SVH
`define SUBARRAY_AT_LEAST_HALF_COUNTER_MACROS_SVH

// implication checked in the next cycle, quiet while reset is high
`define SACNT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication checked in the next cycle, also across reset
`define SACNT_ASSERT_NEXT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sacnt_pkg.sv -----
// shared constants and types of the subarray counter
`timescale 1ns / 1ps

package sacnt_pkg;

   localparam int MAX_LEN_DEF     = 4096;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int VALUE_W         = 32;
   localparam int TOTAL_W         = 24;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   // register index is paddr[2]
   localparam logic CSR_IDX_THRESHOLD = 1'b0;

   // classification of one transaction, passed from front to back
   typedef struct packed {
      logic up;        // value at or above threshold
      logic first;     // restart before this item
      logic skip;      // sequence already full, item only reports
      logic fresh;     // histogram entry not yet written in this sequence
      logic base_one;  // fresh entry is the centre, which starts at one
   } sacnt_ctrl_type;

endpackage

// ----- sv/sacnt_front.sv -----
// front end: classifies items, tracks balance and the touched histogram range
`timescale 1ns / 1ps

module sacnt_front #(
   parameter int MAX_LEN = sacnt_pkg::MAX_LEN_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [sacnt_pkg::VALUE_W-1:0]   threshold,
   input  logic                                   accept,
   input  logic signed [sacnt_pkg::VALUE_W-1:0]   value,
   input  logic                                   first,
   output sacnt_pkg::sacnt_ctrl_type              item_ctrl,
   output logic [$clog2(2*MAX_LEN+1)-1:0]         item_addr
);
   import sacnt_pkg::*;

   localparam int ADDR_W = $clog2(2*MAX_LEN+1);
   localparam int SEEN_W = $clog2(MAX_LEN+1);
   localparam logic [ADDR_W-1:0] CENTRE   = ADDR_W'(MAX_LEN);
   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_LEN);

   logic [ADDR_W-1:0] bal_ff, bal_in, lo_ff, lo_in, hi_ff, hi_in;
   logic              ctr_wr_ff, ctr_wr_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;

   logic [ADDR_W-1:0] bal_cur, lo_cur, hi_cur, addr;
   logic              ctr_cur, up, skip, fresh;
   logic [SEEN_W-1:0] seen_cur;

   always_comb begin
      bal_cur  = first ? CENTRE : bal_ff;
      lo_cur   = first ? CENTRE : lo_ff;
      hi_cur   = first ? CENTRE : hi_ff;
      ctr_cur  = first ? 1'b0 : ctr_wr_ff;
      seen_cur = first ? '0 : seen_ff;

      up    = value >= threshold;
      addr  = up ? bal_cur + ADDR_W'(1) : bal_cur - ADDR_W'(1);
      skip  = seen_cur == SEEN_MAX;
      // balance moves by one, so written entries always form one range
      fresh = (addr > hi_cur) || (addr < lo_cur) || ((addr == CENTRE) && !ctr_cur);

      bal_in    = bal_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      ctr_wr_in = ctr_wr_ff;
      seen_in   = seen_ff;
      if (accept) begin
         bal_in    = bal_cur;
         lo_in     = lo_cur;
         hi_in     = hi_cur;
         ctr_wr_in = ctr_cur;
         seen_in   = seen_cur;
         if (!skip) begin
            bal_in  = addr;
            seen_in = seen_cur + SEEN_W'(1);
            if (addr > hi_cur) begin
               hi_in = addr;
            end
            if (addr < lo_cur) begin
               lo_in = addr;
            end
            if (addr == CENTRE) begin
               ctr_wr_in = 1'b1;
            end
         end
      end

      item_addr          = addr;
      item_ctrl.up       = up;
      item_ctrl.first    = first;
      item_ctrl.skip     = skip;
      item_ctrl.fresh    = fresh;
      item_ctrl.base_one = addr == CENTRE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff    <= CENTRE;
         lo_ff     <= CENTRE;
         hi_ff     <= CENTRE;
         ctr_wr_ff <= 1'b0;
         seen_ff   <= '0;
      end else begin
         bal_ff    <= bal_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         ctr_wr_ff <= ctr_wr_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

// ----- sv/sacnt_queue.sv -----
// short fifo between front and back
`timescale 1ns / 1ps

module sacnt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sacnt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   import sacnt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH-1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = count_ff == CNT_W'(DEPTH);
      not_empty = count_ff != '0;
      pop_data  = entry_ff[rd_ptr_ff];

      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/sacnt_back.sv -----
// back end: histogram memory, running counts and the result register
`timescale 1ns / 1ps

module sacnt_back #(
   parameter int MAX_LEN = sacnt_pkg::MAX_LEN_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  sacnt_pkg::sacnt_ctrl_type          q_ctrl,
   input  logic [$clog2(2*MAX_LEN+1)-1:0]     q_addr,
   output logic                               q_pop,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [sacnt_pkg::TOTAL_W-1:0]      rsp_pair_count,
   output logic                               rsp_overflow
);
   import sacnt_pkg::*;

   localparam int HIST_DEPTH = 2*MAX_LEN+1;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int CNT_W      = $clog2(MAX_LEN+2);

   logic [CNT_W-1:0]   hist_ff [HIST_DEPTH];
   logic [CNT_W-1:0]   rd_data_ff;

   logic               x_valid_ff, x_valid_in;
   sacnt_ctrl_type     x_ctrl_ff;
   logic [ADDR_W-1:0]  x_addr_ff;

   logic [CNT_W-1:0]   loc_ff, loc_in, cur_ff, cur_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               out_valid_ff, out_valid_in;
   logic [TOTAL_W-1:0] out_count_ff;
   logic               out_ovf_ff;

   logic               out_free, x_go;
   logic [CNT_W-1:0]   h, h_inc, loc_base, cur_base, loc_mid;
   logic [TOTAL_W-1:0] tot_base, tot_new;

   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      x_go     = x_valid_ff && out_free;
      q_pop    = q_valid && (!x_valid_ff || x_go);

      // entries outside the range written in this sequence read as their start value
      if (x_ctrl_ff.fresh) begin
         h = x_ctrl_ff.base_one ? CNT_W'(1) : '0;
      end else begin
         h = rd_data_ff;
      end
      h_inc = h + CNT_W'(1);

      loc_base = x_ctrl_ff.first ? CNT_W'(1) : loc_ff;
      cur_base = x_ctrl_ff.first ? CNT_W'(1) : cur_ff;
      tot_base = x_ctrl_ff.first ? '0 : total_ff;

      // cur holds the count at the present balance, needed when stepping down
      loc_mid = x_ctrl_ff.up ? loc_base + h : loc_base - cur_base;
      tot_new = tot_base + TOTAL_W'(loc_mid);

      x_valid_in = q_pop ? 1'b1 : (x_go ? 1'b0 : x_valid_ff);

      loc_in   = loc_ff;
      cur_in   = cur_ff;
      total_in = total_ff;
      if (x_go && !x_ctrl_ff.skip) begin
         loc_in   = loc_mid + CNT_W'(1);
         cur_in   = h_inc;
         total_in = tot_new;
      end

      out_valid_in = x_go ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   // one read and one write per cycle; within a sequence the pop never reads the
   // entry written at the same edge since consecutive items sit on neighboring balances
   always_ff @(posedge clock) begin
      if (x_go && !x_ctrl_ff.skip) begin
         hist_ff[x_addr_ff] <= h_inc;
      end
      if (q_pop) begin
         rd_data_ff <= hist_ff[q_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         x_ctrl_ff <= q_ctrl;
         x_addr_ff <= q_addr;
      end
      if (x_go) begin
         out_count_ff <= x_ctrl_ff.skip ? total_ff : tot_new;
         out_ovf_ff   <= x_ctrl_ff.skip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         loc_ff       <= CNT_W'(1);
         cur_ff       <= CNT_W'(1);
         total_ff     <= '0;
      end else begin
         x_valid_ff   <= x_valid_in;
         out_valid_ff <= out_valid_in;
         loc_ff       <= loc_in;
         cur_ff       <= cur_in;
         total_ff     <= total_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pair_count = out_count_ff;
   assign rsp_overflow   = out_ovf_ff;

endmodule

// ----- sv/subarray_at_least_half_counter.sv -----
// top level of the subarray counter: csr, front, queue and back
`timescale 1ns / 1ps

//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | req_value, req_first
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_pair_count, rsp_overflow
//  csr     | in/out    | csr_psel / csr_penable  | csr_paddr, csr_pwdata, csr_prdata
//
//  one transaction per cycle sustained while rsp_stall is low; the histogram
//  memory does one read and one write per cycle, and the pipeline is queue,
//  read stage, result register. rsp_valid rises at the earliest once an item
//  has left the queue and the read stage. reset is synchronous; no clearing pass,
//  the histogram needs none, a restart never stalls. req_stall rises only when the queue is full.

module subarray_at_least_half_counter #(
   parameter int MAX_LEN     = sacnt_pkg::MAX_LEN_DEF,
   parameter int QUEUE_DEPTH = sacnt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sacnt_pkg::VALUE_W-1:0]  req_value,
   input  logic                                  req_first,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sacnt_pkg::TOTAL_W-1:0]         rsp_pair_count,
   output logic                                  rsp_overflow,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sacnt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sacnt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sacnt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import sacnt_pkg::*;

   localparam int ADDR_W = $clog2(2*MAX_LEN+1);
   localparam int ITEM_W = $bits(sacnt_ctrl_type) + ADDR_W;

   logic signed [VALUE_W-1:0] threshold_ff, threshold_in;
   logic                      csr_wr, csr_hit;

   logic                      accept, q_full, q_not_empty, q_pop;
   sacnt_ctrl_type            f_ctrl, q_ctrl;
   logic [ADDR_W-1:0]         f_addr, q_addr;
   logic [ITEM_W-1:0]         q_pop_data;

   always_comb begin
      csr_pready   = 1'b1;
      csr_hit      = csr_paddr[2] == CSR_IDX_THRESHOLD;
      csr_wr       = csr_psel && csr_penable && csr_pwrite && csr_pready;
      threshold_in = (csr_wr && csr_hit) ? $signed(csr_pwdata) : threshold_ff;
      csr_prdata   = csr_hit ? threshold_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   sacnt_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold_ff),
      .accept    (accept),
      .value     (req_value),
      .first     (req_first),
      .item_ctrl (f_ctrl),
      .item_addr (f_addr)
   );

   sacnt_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({f_ctrl, f_addr}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   assign {q_ctrl, q_addr} = q_pop_data;

   sacnt_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_not_empty),
      .q_ctrl         (q_ctrl),
      .q_addr         (q_addr),
      .q_pop          (q_pop),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_pair_count (rsp_pair_count),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ----- sv/sacnt_checker.sv -----
// port level checks of the subarray counter and their bind
`timescale 1ns / 1ps
`include "subarray_at_least_half_counter_macros.svh"

module sacnt_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic signed [sacnt_pkg::VALUE_W-1:0]  req_value,
   input logic                                  req_first,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [sacnt_pkg::TOTAL_W-1:0]         rsp_pair_count,
   input logic                                  rsp_overflow,
   input logic                                  csr_psel,
   input logic                                  csr_penable,
   input logic                                  csr_pwrite,
   input logic [sacnt_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input logic [sacnt_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input logic [sacnt_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input logic                                  csr_pready
);
   import sacnt_pkg::*;

   // a held result keeps its values
   `SACNT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pair_count) && $stable(rsp_overflow), "rsp transaction changed while stalled")

   // a stalled request keeps its values
   `SACNT_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_value) && $stable(req_first), "req transaction changed while stalled")

   // reset empties the result register and the queue
   `SACNT_ASSERT_NEXT_RST(a_rst_rsp, reset, !rsp_valid, "rsp_valid high right after reset")
   `SACNT_ASSERT_NEXT_RST(a_rst_req, reset, !req_stall, "req_stall high right after reset")

   // threshold reads back what was written
   `SACNT_ASSERT_NEXT(a_csr_rdback, csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr[2] == CSR_IDX_THRESHOLD), (csr_paddr[2] != CSR_IDX_THRESHOLD) || (csr_prdata == $past(csr_pwdata)), "threshold read back differs from last write")

endmodule

bind subarray_at_least_half_counter sacnt_checker u_checker (.*);
